FILE: design/lwcq_pkg.sv
// Shared types and constants of the latest-wins coalescing queue.
package lwcq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 64;
   localparam int STATUS_W    = 3;
   localparam int OCC_W       = 5;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_QUEUED   = 3'd0,
      STATUS_REPLACED = 3'd1,
      STATUS_STALE    = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_POPPED   = 3'd4,
      STATUS_EMPTY    = 3'd5
   } status_type;

   // class given to an item by the front part
   typedef enum logic [1:0] {
      KIND_PUSH = 2'd0,
      KIND_DRAG = 2'd1,
      KIND_POP  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] request_id;
      logic [DATA_W-1:0] gesture_key;
      logic [DATA_W-1:0] update_seq;
   } item_type;

   typedef enum logic [1:0] {
      S_MATCH = 2'b01,
      S_EXEC  = 2'b10
   } back_state_type;

endpackage

FILE: design/lwcq_channels.sv
// Request and response channel interfaces of the coalescing queue.
interface lwcq_req_if import lwcq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [DATA_W-1:0] request_id;
   logic              drag_flag;
   logic [DATA_W-1:0] gesture_key;
   logic [DATA_W-1:0] update_seq;

   modport source (output valid, cmd, request_id, drag_flag, gesture_key, update_seq,
                   input ready);
   modport sink (input valid, cmd, request_id, drag_flag, gesture_key, update_seq,
                 output ready);
endinterface

interface lwcq_rsp_if import lwcq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   cancelled_id;
   logic [DATA_W-1:0]   head_id;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, status, cancelled_id, head_id, occupancy, input ready);
   modport sink (input valid, status, cancelled_id, head_id, occupancy, output ready);
endinterface

FILE: design/lwcq_front.sv
// Front part: accepts requests, classifies them and buffers them in a two-entry queue.
module lwcq_front import lwcq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   lwcq_req_if.sink req_if,
   output item_type out_item,
   output logic     out_valid,
   input  logic     out_take
);

   localparam logic [1:0] FULL_CNT = 2'd2;

   item_type   slots_ff [2];
   item_type   slots_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   new_item;
   logic       push;

   always_comb begin
      new_item.request_id  = req_if.request_id;
      new_item.gesture_key = req_if.gesture_key;
      new_item.update_seq  = req_if.update_seq;
      if (req_if.cmd == CMD_POP) begin
         new_item.kind = KIND_POP;
      end else if (req_if.drag_flag) begin
         new_item.kind = KIND_DRAG;
      end else begin
         new_item.kind = KIND_PUSH;
      end
   end

   assign req_if.ready = (cnt_ff != FULL_CNT);
   assign push         = req_if.valid && req_if.ready;
   assign out_valid    = (cnt_ff != 2'd0);
   assign out_item     = slots_ff[rd_ptr_ff];

   always_comb begin
      slots_in  = slots_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         slots_in[wr_ptr_ff] = new_item;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (out_take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, out_take})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: design/lwcq_back.sv
// Back part: entry store, parallel gesture match, compaction, append and result register.
module lwcq_back import lwcq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  item_type    in_item,
   input  logic        in_valid,
   output logic        in_take,
   lwcq_rsp_if.source  rsp_if
);

   logic [DATA_W-1:0] ids_ff   [QUEUE_DEPTH];
   logic [DATA_W-1:0] ids_in   [QUEUE_DEPTH];
   logic              drags_ff [QUEUE_DEPTH];
   logic              drags_in [QUEUE_DEPTH];
   logic [DATA_W-1:0] gests_ff [QUEUE_DEPTH];
   logic [DATA_W-1:0] gests_in [QUEUE_DEPTH];
   logic [DATA_W-1:0] seqs_ff  [QUEUE_DEPTH];
   logic [DATA_W-1:0] seqs_in  [QUEUE_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   back_state_type         state_ff, state_in;
   item_type               item_ff;
   logic [QUEUE_DEPTH-1:0] first_oh_ff, mask_ff;
   logic                   matched_ff;

   logic [QUEUE_DEPTH-1:0] hit, first_oh, shift_mask;
   logic [DATA_W-1:0]      sel_id, sel_seq;
   logic                   exec_go;

   status_type        status_n;
   logic [DATA_W-1:0] cancel_n, head_n;
   logic              shift_en, app_en;
   logic [CNT_W-1:0]  app_idx;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [DATA_W-1:0]   cancel_ff, head_ff;
   logic [OCC_W-1:0]    occ_ff;

   // match against all live entries at once
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_hit
      assign hit[i] = (in_item.kind == KIND_DRAG) && (CNT_W'(i) < count_ff) &&
                      drags_ff[i] && (gests_ff[i] == in_item.gesture_key);
   end

   assign first_oh = hit & (~hit + QUEUE_DEPTH'(1));
   assign in_take  = (state_ff == S_MATCH) && in_valid;
   assign exec_go  = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_MATCH: if (in_valid) state_in = S_EXEC;
         S_EXEC:  if (exec_go) state_in = S_MATCH;
         default: state_in = S_MATCH;
      endcase
   end

   always_comb begin
      sel_id  = '0;
      sel_seq = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (first_oh_ff[i]) begin
            sel_id  = sel_id | ids_ff[i];
            sel_seq = sel_seq | seqs_ff[i];
         end
      end
   end

   always_comb begin
      status_n   = STATUS_QUEUED;
      cancel_n   = '0;
      head_n     = '0;
      shift_en   = 1'b0;
      app_en     = 1'b0;
      app_idx    = count_ff;
      count_in   = count_ff;
      shift_mask = mask_ff;
      case (item_ff.kind)
         KIND_POP: begin
            shift_mask = '1;
            if (count_ff == '0) begin
               status_n = STATUS_EMPTY;
            end else begin
               status_n = STATUS_POPPED;
               head_n   = ids_ff[0];
               shift_en = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (matched_ff) begin
               if (sel_seq < item_ff.update_seq) begin
                  status_n = STATUS_REPLACED;
                  cancel_n = sel_id;
                  shift_en = 1'b1;
                  app_en   = 1'b1;
                  app_idx  = count_ff - CNT_W'(1);
               end else begin
                  status_n = STATUS_STALE;
                  cancel_n = item_ff.request_id;
               end
            end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               status_n = STATUS_FULL;
            end else begin
               app_en   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
      endcase
   end

   // per-slot update: close up behind the removed entry, then append
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
      always_comb begin
         ids_in[i]   = ids_ff[i];
         drags_in[i] = drags_ff[i];
         gests_in[i] = gests_ff[i];
         seqs_in[i]  = seqs_ff[i];
         if (exec_go && shift_en && shift_mask[i]) begin
            if (i < QUEUE_DEPTH - 1) begin
               ids_in[i]   = ids_ff[(i + 1) % QUEUE_DEPTH];
               drags_in[i] = drags_ff[(i + 1) % QUEUE_DEPTH];
               gests_in[i] = gests_ff[(i + 1) % QUEUE_DEPTH];
               seqs_in[i]  = seqs_ff[(i + 1) % QUEUE_DEPTH];
            end
         end
         if (exec_go && app_en && (app_idx == CNT_W'(i))) begin
            ids_in[i]   = item_ff.request_id;
            drags_in[i] = (item_ff.kind == KIND_DRAG);
            gests_in[i] = item_ff.gesture_key;
            seqs_in[i]  = item_ff.update_seq;
         end
      end

      always_ff @(posedge clock) begin
         ids_ff[i]   <= ids_in[i];
         drags_ff[i] <= drags_in[i];
         gests_ff[i] <= gests_in[i];
         seqs_ff[i]  <= seqs_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         item_ff     <= in_item;
         first_oh_ff <= first_oh;
         mask_ff     <= ~(first_oh - QUEUE_DEPTH'(1));
         matched_ff  <= (hit != '0);
      end
      if (exec_go) begin
         status_ff <= status_n;
         cancel_ff <= cancel_n;
         head_ff   <= head_n;
         occ_ff    <= OCC_W'(count_in);
      end
      if (reset) begin
         state_ff     <= S_MATCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (exec_go) begin
            count_ff <= count_in;
         end
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.cancelled_id = cancel_ff;
   assign rsp_if.head_id      = head_ff;
   assign rsp_if.occupancy    = occ_ff;

endmodule

FILE: design/latest_wins_coalescing_queue_top.sv
// Top level of the latest-wins coalescing queue.
//
//  channel  dir  handshake     payload
//  req_if   in   valid/ready   cmd, request_id, drag_flag, gesture_key, update_seq
//  rsp_if   out  valid/ready   status, cancelled_id, head_id, occupancy
//
// The back part matches each item's gesture against all entries, then compacts,
// appends and loads the result register.
// The front buffers two requests; the back part finishes each before taking the
// next, so steady input fills the front and req_if drops ready until a slot frees.
// A result waiting on rsp_if holds the back part in its execute step only.
// Reset (synchronous) empties the queue; entry storage is not cleared.
module latest_wins_coalescing_queue_top import lwcq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lwcq_req_if.sink   req_if,
   lwcq_rsp_if.source rsp_if
);

   item_type front_item;
   logic     front_valid;
   logic     front_take;

   lwcq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_item  (front_item),
      .out_valid (front_valid),
      .out_take  (front_take)
   );

   lwcq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_item  (front_item),
      .in_valid (front_valid),
      .in_take  (front_take),
      .rsp_if   (rsp_if)
   );

endmodule
